/* rtl/rtc3w_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rtc3w_pkg;

    // Item selector codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Transaction modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Half bit phases
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    // Command byte of a clock burst read
    localparam logic [7:0] BURST_CMD = 8'hBF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       io_in;
    } cmd_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_drive;
        logic       io_out;
        logic       byte_valid;
        logic [2:0] byte_index;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       done_res;
        logic       cmd_rejected;
    } res_t;

endpackage

`default_nettype wire

/* rtl/three_wire_rtc_serial_master_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Three-wire RTC serial master (CE, SCLK, shared IO).
// Input channel cmd/cmd_valid/cmd_ready takes one item: a tick (one half bit
// period), a register write start (reg_addr, write_data) or a burst read
// start. Output channel res/res_valid/res_ready returns exactly one item for
// each accepted input item, carrying the pin levels after that item, any
// completed burst byte and the busy, done and rejected flags.
// The result is registered and appears in the cycle after the input item is accepted.
// Throughput: one item per cycle while results are taken; the state update
// and result come from one pass over the state registers and incoming item.
// A write takes 16 bits, a burst read 8 + 8*BURST_BYTES bits, each two ticks,
// plus one tick that drops CE.
// Reset puts the block idle with CE low, SCLK low and IO released.
// When the receiver stalls, the result register holds and cmd_ready drops
// until it is taken; no item is lost or repeated.
module three_wire_rtc_serial_master_unit #(
    parameter int BURST_BYTES = 8,
    parameter int KEPT_BYTES  = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire rtc3w_pkg::cmd_t   cmd,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output rtc3w_pkg::res_t        res
);

    localparam int TOTAL_READ = 8 + 8 * BURST_BYTES;
    localparam int CW = $clog2(TOTAL_READ + 1);
    localparam int IW = (CW - 3 > 3) ? CW - 3 : 3;

    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [1:0]    phase_reg, phase_next;
    logic [15:0]   send_reg, send_next;
    logic [7:0]    recv_reg, recv_next;
    logic          ce_reg, ce_next;
    logic          sclk_reg, sclk_next;
    logic          drive_reg, drive_next;
    logic          out_reg, out_next;

    rtc3w_pkg::res_t res_reg, res_next;
    logic            res_valid_reg;

    logic          accept;
    logic          sending;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] total_bits;
    logic [IW-1:0] idx_w;
    logic [7:0]    recv_shifted;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign sending      = (mode_reg == rtc3w_pkg::MODE_WRITE) || (bit_cnt_reg < CW'(8));
    assign cnt_inc      = bit_cnt_reg + CW'(1);
    assign total_bits   = (mode_reg == rtc3w_pkg::MODE_WRITE) ? CW'(16) : CW'(TOTAL_READ);
    assign idx_w        = IW'(cnt_inc[CW-1:3]) - IW'(2);
    assign recv_shifted = {cmd.io_in, recv_reg[7:1]};

    // Advance the transaction by one item
    always_comb
    begin
        mode_next    = mode_reg;
        bit_cnt_next = bit_cnt_reg;
        phase_next   = phase_reg;
        send_next    = send_reg;
        recv_next    = recv_reg;
        ce_next      = ce_reg;
        sclk_next    = sclk_reg;
        drive_next   = drive_reg;
        out_next     = out_reg;
        res_next     = '0;

        if (cmd.operation == rtc3w_pkg::OP_WRITE || cmd.operation == rtc3w_pkg::OP_READ)
        begin
            if (mode_reg != rtc3w_pkg::MODE_IDLE)
            begin
                res_next.cmd_rejected = 1'b1;
            end
            else
            begin
                if (cmd.operation == rtc3w_pkg::OP_WRITE)
                begin
                    mode_next = rtc3w_pkg::MODE_WRITE;
                    send_next = {cmd.write_data, cmd.reg_addr};
                end
                else
                begin
                    mode_next = rtc3w_pkg::MODE_READ;
                    send_next = {8'd0, rtc3w_pkg::BURST_CMD};
                end
                bit_cnt_next = '0;
                phase_next   = rtc3w_pkg::PH_LOW;
                recv_next    = '0;
                sclk_next    = 1'b0;
                ce_next      = 1'b1;
            end
        end
        else if (mode_reg != rtc3w_pkg::MODE_IDLE)
        begin
            unique case (phase_reg)
                rtc3w_pkg::PH_LOW:
                begin
                    // Set data with SCLK low
                    sclk_next  = 1'b0;
                    drive_next = sending;
                    out_next   = sending ? send_reg[0] : 1'b1;
                    phase_next = rtc3w_pkg::PH_HIGH;
                end
                rtc3w_pkg::PH_HIGH:
                begin
                    // Raise SCLK, shift out or sample in
                    sclk_next = 1'b1;
                    if (sending)
                        send_next = {1'b0, send_reg[15:1]};
                    else
                        recv_next = recv_shifted;
                    bit_cnt_next = cnt_inc;
                    if (mode_reg == rtc3w_pkg::MODE_READ && cnt_inc > CW'(8)
                        && cnt_inc[2:0] == 3'd0 && 32'(idx_w) < KEPT_BYTES)
                    begin
                        res_next.byte_valid = 1'b1;
                        res_next.byte_index = idx_w[2:0];
                        res_next.read_byte  = sending ? recv_reg : recv_shifted;
                    end
                    phase_next = (cnt_inc >= total_bits) ? rtc3w_pkg::PH_END
                                                         : rtc3w_pkg::PH_LOW;
                end
                default:
                begin
                    // Drop CE and end the transaction
                    ce_next          = 1'b0;
                    res_next.done_res = 1'b1;
                    mode_next        = rtc3w_pkg::MODE_IDLE;
                    bit_cnt_next     = '0;
                    phase_next       = rtc3w_pkg::PH_LOW;
                end
            endcase
        end

        res_next.chip_enable  = ce_next;
        res_next.serial_clock = sclk_next;
        res_next.io_drive     = drive_next;
        res_next.io_out       = out_next;
        res_next.busy_res     = (mode_next != rtc3w_pkg::MODE_IDLE);
    end

    // Hold transaction state and pin levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rtc3w_pkg::MODE_IDLE;
            bit_cnt_reg <= '0;
            phase_reg   <= rtc3w_pkg::PH_LOW;
            send_reg    <= '0;
            recv_reg    <= '0;
            ce_reg      <= 1'b0;
            sclk_reg    <= 1'b0;
            drive_reg   <= 1'b0;
            out_reg     <= 1'b1;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            bit_cnt_reg <= bit_cnt_next;
            phase_reg   <= phase_next;
            send_reg    <= send_next;
            recv_reg    <= recv_next;
            ce_reg      <= ce_next;
            sclk_reg    <= sclk_next;
            drive_reg   <= drive_next;
            out_reg     <= out_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

/* rtl/rtc3w_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rtc3w_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            res_valid,
    input wire logic            res_ready,
    input wire rtc3w_pkg::res_t res
);

    // A stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result item changed");

    // A burst byte only completes inside an open transaction
    a_byte_in_txn: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.byte_valid |-> res.chip_enable && res.busy_res)
        else $error("byte reported outside a transaction");

    // Done drops CE and leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.chip_enable && !res.busy_res)
        else $error("done without CE low and idle");

    // A rejected start only happens while busy
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.cmd_rejected |-> res.busy_res && res.chip_enable)
        else $error("start rejected while idle");

    // Released IO reads high
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.io_drive |-> res.io_out)
        else $error("released IO not high");

endmodule

bind three_wire_rtc_serial_master_unit rtc3w_checker u_rtc3w_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire

/* verif/three_wire_rtc_serial_master_unit_test.sv */
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_unit_test;

    import rtc3w_pkg::*;

    localparam int BURST_BYTES = 8;
    localparam int KEPT_BYTES  = 7;
    // Selector value with no operation of its own; the block treats it as a tick
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    // Shadow state of the serial master
    logic [1:0]  xfer_mode = MODE_IDLE;
    logic [6:0]  bits_done = '0;
    logic [1:0]  half_ph = PH_LOW;
    logic [15:0] tx_shift = '0;
    logic [7:0]  rx_shift = '0;
    logic        ce_lvl = 1'b0;
    logic        sclk_lvl = 1'b0;
    logic        drive_lvl = 1'b0;
    logic        out_lvl = 1'b1;

    res_t pending_pin_results[$];
    int   worked_items = 0;
    int   fail_count = 0;
    int   mismatch_count = 0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;

    three_wire_rtc_serial_master_unit #(
        .BURST_BYTES(BURST_BYTES),
        .KEPT_BYTES (KEPT_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Advance the shadow master by one item and return the pin levels after it
    function automatic res_t predict_pins_after(input cmd_t item);
        res_t r;
        logic [6:0] frame_bits;
        logic sending;
        int byte_pos;
        r = '0;
        if (item.operation == OP_WRITE || item.operation == OP_READ)
        begin
            if (xfer_mode != MODE_IDLE)
            begin
                r.cmd_rejected = 1'b1;
            end
            else
            begin
                xfer_mode = (item.operation == OP_WRITE) ? MODE_WRITE : MODE_READ;
                tx_shift = (item.operation == OP_WRITE) ? {item.write_data, item.reg_addr}
                                                        : {8'h00, BURST_CMD};
                bits_done = '0;
                half_ph = PH_LOW;
                rx_shift = '0;
                sclk_lvl = 1'b0;
                ce_lvl = 1'b1;
            end
        end
        else if (xfer_mode != MODE_IDLE)
        begin
            frame_bits = (xfer_mode == MODE_WRITE) ? 7'd16 : 7'(8 + 8 * BURST_BYTES);
            sending = (xfer_mode == MODE_WRITE) || (bits_done < 7'd8);
            case (half_ph)
                PH_LOW:
                begin
                    sclk_lvl = 1'b0;
                    drive_lvl = sending;
                    out_lvl = sending ? tx_shift[0] : 1'b1;
                    half_ph = PH_HIGH;
                end
                PH_HIGH:
                begin
                    sclk_lvl = 1'b1;
                    if (sending)
                        tx_shift = tx_shift >> 1;
                    else
                        rx_shift = {item.io_in, rx_shift[7:1]};
                    bits_done = bits_done + 7'd1;
                    // Report a kept byte once its eighth bit is in
                    if (xfer_mode == MODE_READ && bits_done > 7'd8 && bits_done[2:0] == 3'd0)
                    begin
                        byte_pos = (int'(bits_done) - 8) / 8 - 1;
                        if (byte_pos < KEPT_BYTES)
                        begin
                            r.byte_valid = 1'b1;
                            r.byte_index = byte_pos[2:0];
                            r.read_byte = rx_shift;
                        end
                    end
                    half_ph = (bits_done >= frame_bits) ? PH_END : PH_LOW;
                end
                default:
                begin
                    ce_lvl = 1'b0;
                    r.done_res = 1'b1;
                    xfer_mode = MODE_IDLE;
                    bits_done = '0;
                    half_ph = PH_LOW;
                end
            endcase
        end
        r.chip_enable = ce_lvl;
        r.serial_clock = sclk_lvl;
        r.io_drive = drive_lvl;
        r.io_out = out_lvl;
        r.busy_res = (xfer_mode != MODE_IDLE);
        return r;
    endfunction

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic send_item(input cmd_t item);
        bit took;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd <= item;
        cmd_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            took = cmd_ready;
            @(posedge clk);
        end
        while (!took);
        if (xfer_mode != MODE_IDLE || item.operation == OP_WRITE || item.operation == OP_READ)
            worked_items++;
        pending_pin_results.push_back(predict_pins_after(item));
    endtask

    // Open a transaction and tick it through to the end; noisy adds spare
    // selectors and starts that arrive while busy
    task automatic run_transaction(input logic [1:0] op, input logic [7:0] addr,
                                   input logic [7:0] data, input bit noisy);
        cmd_t item;
        item = '{operation: op, reg_addr: addr, write_data: data,
                 io_in: 1'($urandom_range(0, 1))};
        send_item(item);
        while (xfer_mode != MODE_IDLE)
        begin
            item.operation = OP_TICK;
            if (noisy && $urandom_range(0, 7) == 0)
                item.operation = OP_SPARE;
            if (noisy && $urandom_range(0, 15) == 0)
                item.operation = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
            item.reg_addr = 8'($urandom);
            item.write_data = 8'($urandom);
            item.io_in = 1'($urandom_range(0, 1));
            send_item(item);
        end
    endtask

    task automatic test_idle_ticks();
        send_item('{operation: OP_TICK, reg_addr: 8'hFF, write_data: 8'hFF, io_in: 1'b1});
        send_item('{operation: OP_SPARE, reg_addr: 8'h00, write_data: 8'h00, io_in: 1'b0});
        send_item('{operation: OP_SPARE, reg_addr: 8'hFF, write_data: 8'hFF, io_in: 1'b1});
        send_item('{operation: OP_TICK, reg_addr: 8'h00, write_data: 8'h00, io_in: 1'b0});
    endtask

    task automatic test_register_write();
        run_transaction(OP_WRITE, 8'hFF, 8'h00, 1'b0);
        run_transaction(OP_WRITE, 8'h00, 8'hFF, 1'b0);
    endtask

    task automatic test_burst_read();
        run_transaction(OP_READ, 8'h00, 8'h00, 1'b1);
        run_transaction(OP_READ, 8'hFF, 8'hFF, 1'b0);
    endtask

    task automatic test_busy_rejects();
        run_transaction(OP_WRITE, 8'hA5, 8'h5A, 1'b1);
    endtask

    task automatic test_receiver_backpressure();
        hold_req = 1'b1;
        run_transaction(OP_WRITE, 8'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic test_random_traffic();
        int base;
        cmd_t noise;
        base = worked_items;
        while (worked_items - base < RANDOM_ITEMS)
        begin
            // Drop idling for the last quarter
            if (worked_items - base >= RANDOM_ITEMS * 3 / 4)
                idle_on = 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                noise = '{operation: ($urandom_range(0, 1) == 0) ? OP_TICK : OP_SPARE,
                          reg_addr: 8'($urandom), write_data: 8'($urandom),
                          io_in: 1'($urandom_range(0, 1))};
                send_item(noise);
            end
            else
            begin
                run_transaction(($urandom_range(0, 9) < 6) ? OP_WRITE : OP_READ,
                                8'($urandom), 8'($urandom), $urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Drive the result side: random stalls, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                res_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // Compare each taken result with the oldest expectation
    initial
    begin
        res_t want;
        bit bad;
        forever
        begin
            @(negedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                if (pending_pin_results.size() == 0)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result %p", res);
                end
                else
                begin
                    want = pending_pin_results.pop_front();
                    bad = (res.chip_enable !== want.chip_enable)
                        || (res.serial_clock !== want.serial_clock)
                        || (res.io_drive !== want.io_drive)
                        || (res.io_out !== want.io_out)
                        || (res.byte_valid !== want.byte_valid)
                        || (res.byte_index !== want.byte_index)
                        || (res.read_byte !== want.read_byte)
                        || (res.busy_res !== want.busy_res)
                        || (res.done_res !== want.done_res)
                        || (res.cmd_rejected !== want.cmd_rejected);
                    if (bad)
                    begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected %p got %p", want, res);
                    end
                end
            end
        end
    end

    // Stop the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("three_wire_rtc_serial_master_unit regression: fail");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_register_write();
        test_burst_read();
        test_busy_rejects();
        test_receiver_backpressure();
        test_random_traffic();
        cmd_valid <= 1'b0;
        // Drain outstanding results, then let the output settle
        while (pending_pin_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_pin_results.size() == 0)
            $display("three_wire_rtc_serial_master_unit regression: pass");
        else
            $display("three_wire_rtc_serial_master_unit regression: fail");
        $finish;
    end

endmodule
